// File: hw/rtl/spt_pkg.sv
// Shared types, constants and helpers of the Stanley path tracker.
package spt_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_POSE   = 2'd2
  } opcode_t;

  localparam logic [2:0] CFG_CROSS_GAIN    = 3'd0;
  localparam logic [2:0] CFG_STEER_GAIN    = 3'd1;
  localparam logic [2:0] CFG_DRIVE_SPEED   = 3'd2;
  localparam logic [2:0] CFG_GOAL_RADIUS   = 3'd3;
  localparam logic [2:0] CFG_POINT_SPACING = 3'd4;
  localparam logic [2:0] CFG_POSE_TIMEOUT  = 3'd5;

  localparam logic [15:0] RST_CROSS_GAIN    = 16'd2458;
  localparam logic [15:0] RST_STEER_GAIN    = 16'd819;
  localparam logic [15:0] RST_DRIVE_SPEED   = 16'd819;
  localparam logic [31:0] RST_GOAL_RADIUS   = 32'd32768;
  localparam logic [31:0] RST_POINT_SPACING = 32'd3277;
  localparam logic [31:0] RST_POSE_TIMEOUT  = 32'd1000000;

  localparam int DIFF_W = 33;
  localparam int AT_W   = 50;
  localparam int MUL_W  = 34;
  localparam int DIV_N  = 48;
  localparam int DIV_D  = 32;
  localparam int CORDIC_STEPS = 24;

  localparam logic signed [16:0] PI_Q13      = 17'sd25736;
  localparam logic signed [16:0] TWO_PI_Q13  = 17'sd51472;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [15:0] RATE_LIMIT  = 16'sd24576;
  localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [33:0] US_PER_S    = 34'sd1000000;

  function automatic logic signed [31:0] atan_step(input logic [4:0] k);
    logic signed [31:0] a;
    case (k)
      5'd0: a = 32'sd210828714;
      5'd1: a = 32'sd124459457;
      5'd2: a = 32'sd65760959;
      5'd3: a = 32'sd33381290;
      5'd4: a = 32'sd16755422;
      5'd5: a = 32'sd8385879;
      5'd6: a = 32'sd4193963;
      5'd7: a = 32'sd2097109;
      5'd8: a = 32'sd1048571;
      5'd9: a = 32'sd524287;
      default: a = 32'sd1 <<< (5'd28 - k);
    endcase
    return a;
  endfunction

  function automatic logic signed [DIFF_W-1:0] coord_diff(input logic signed [31:0] a,
                                                          input logic signed [31:0] b);
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

endpackage

// File: hw/rtl/stanley_path_tracker.sv
// Stanley path tracker top level: path memory, sequencer and shared arithmetic.
//
// Input beats carry an opcode: clear path, append point, or pose. Only a pose
// can produce an output beat, and only when a path is loaded and the pose gap
// is within pose_timeout. Items are handled one at a time; in_ready is high
// while the sequencer is idle, also when an output beat still waits.
// Clear only resets the path registers; an append runs one distance evaluation.
// A pose inside the goal radius also runs one distance evaluation. A tracking
// pose further visits N path points in the forward nearest-point walk;
// each visit is one memory read and one iterative distance (squares plus 32
// root steps).
// A tracking pose uses two atan2 runs and two 48-step divides; a zero drive
// speed skips one divide and one atan2 run, a zero pose gap skips one divide.
// Configuration writes on cfg_we take effect at once and must only occur
// while idle. Reset clears the path, the look-ahead estimate, the pose time
// and restores register defaults; the path memory is not cleared, since
// entries beyond the path length are never read.
// When out_ready is low the result is held in the output register and the
// sequencer waits before producing the next result.
module stanley_path_tracker #(
  parameter int PATH_DEPTH      = 1024,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [15:0] in_robot_heading,
  input  logic [31:0]        in_timestamp_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_angular_rate,
  output logic [15:0]        out_linear_speed,
  output logic               out_goal_reached,
  output logic signed [16:0] out_heading_error,
  output logic [31:0]        out_cross_distance,
  output logic [9:0]         out_nearest_index,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import spt_pkg::*;

  localparam int AW  = $clog2(PATH_DEPTH);
  localparam int CW  = $clog2(PATH_DEPTH + 1);
  localparam int CW1 = CW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_APP_LEN, S_GOAL_WAIT, S_GOAL_GO, S_GOAL_LEN,
    S_SR_WAIT, S_SR_GO, S_SR_LEN, S_LA, S_PI_WAIT, S_PI_CAP,
    S_PJ_WAIT, S_PJ_CAP, S_MUL_A, S_MUL_B, S_SIDE, S_AT_H,
    S_CT_MUL, S_CT_DIV, S_CT_DIVW, S_CT_AT, S_INNER, S_NUM1,
    S_NUM2, S_NUM3, S_RATE_DIV, S_OUT
  } state_t;

  state_t state_r;

  logic [15:0] cross_gain_r, steer_gain_r, drive_speed_r;
  logic [31:0] goal_radius_r, point_spacing_r, pose_timeout_r;

  logic [CW-1:0]      count_r, step_r, run_r, h_r, last_w, h_nxt;
  logic               path_valid_r;
  logic [AW-1:0]      nearest_r, idx_r, j_r, rd_addr_r, i_start;
  logic signed [31:0] anchor_x_r, anchor_y_r, cx_r, cy_r;
  logic signed [31:0] pix_r, piy_r, pjx_r, pjy_r, ram_x, ram_y;
  logic [31:0]        prev_time_r, dt_r, dt_w;
  logic signed [16:0] hd_r, hd_in;
  logic               first_r, num_neg_r;
  logic [31:0]        dprev_r, dfirst_r, d_r;
  logic signed [67:0] p_r, mul_r, num_abs;
  logic signed [33:0] mul_a, mul_b;
  logic signed [1:0]  side_r;
  logic signed [17:0] delta_r, inner_r;
  logic signed [15:0] ct_r;
  logic [CW1-1:0]     la_sum, step_sum;
  logic [15:0]        rate_mag;

  logic signed [15:0] res_rate;
  logic [15:0]        res_speed;
  logic               res_goal;
  logic signed [16:0] res_delta;
  logic [31:0]        res_dist;
  logic [AW-1:0]      res_idx;
  logic               out_valid_r;

  logic               in_fire, ram_we;
  logic [63:0]        ram_rdata;
  logic               vlen_start, vlen_done;
  logic signed [DIFF_W-1:0] vlen_dx, vlen_dy;
  logic [31:0]        vlen_len;
  logic               at_start, at_done;
  logic signed [AT_W-1:0] at_y, at_x;
  logic signed [15:0] at_angle;
  logic               div_start, div_done;
  logic [DIV_N-1:0]   div_num, div_q;
  logic [DIV_D-1:0]   div_den;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign ram_we    = in_fire && (opcode_t'(in_opcode) == OP_APPEND) &&
                     (count_r < CW'(PATH_DEPTH));
  assign ram_x     = signed'(ram_rdata[31:0]);
  assign ram_y     = signed'(ram_rdata[63:32]);
  assign last_w    = count_r - CW'(1);
  assign dt_w      = in_timestamp_us - prev_time_r;
  assign i_start   = (CW'(nearest_r) > last_w) ? '0 : nearest_r;
  assign h_nxt     = first_r ? (CW'(idx_r) + CW'(1)) : (h_r + CW'(1));
  assign la_sum    = CW1'(idx_r) + CW1'(step_r);
  assign step_sum  = CW1'(step_r) + CW1'(run_r);
  assign num_abs   = mul_r[67] ? -mul_r : mul_r;
  assign rate_mag  = (div_q > DIV_N'(RATE_LIMIT)) ? RATE_LIMIT : div_q[15:0];

  always_comb begin
    hd_in = 17'(in_robot_heading);
    if (hd_in > PI_Q13) begin
      hd_in = hd_in - TWO_PI_Q13;
    end else if (hd_in < -PI_Q13) begin
      hd_in = hd_in + TWO_PI_Q13;
    end
  end

  spt_ram #(.WIDTH(64), .DEPTH(PATH_DEPTH)) u_path_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_coord_y, in_coord_x}),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    vlen_start = 1'b0;
    at_start   = 1'b0;
    div_start  = 1'b0;
    vlen_dx    = coord_diff(in_coord_x, (count_r == '0) ? in_coord_x : anchor_x_r);
    vlen_dy    = coord_diff(in_coord_y, (count_r == '0) ? in_coord_y : anchor_y_r);
    at_y       = AT_W'(coord_diff(pjy_r, piy_r));
    at_x       = AT_W'(coord_diff(pjx_r, pix_r));
    div_num    = num_abs[DIV_N+11:12];
    div_den    = dt_r;
    mul_a      = MUL_W'(coord_diff(pjx_r, pix_r));
    mul_b      = MUL_W'(coord_diff(cy_r, piy_r));
    case (state_r)
      S_IDLE: begin
        vlen_start = ram_we;
      end
      S_GOAL_GO, S_SR_GO: begin
        vlen_start = 1'b1;
        vlen_dx    = coord_diff(ram_x, cx_r);
        vlen_dy    = coord_diff(ram_y, cy_r);
      end
      S_MUL_B: begin
        mul_a = MUL_W'(coord_diff(pjy_r, piy_r));
        mul_b = MUL_W'(coord_diff(cx_r, pix_r));
      end
      S_SIDE: begin
        at_start = 1'b1;
      end
      S_CT_MUL: begin
        mul_a = {18'd0, cross_gain_r};
        mul_b = {2'd0, d_r};
      end
      S_CT_DIV: begin
        div_start = 1'b1;
        div_num   = mul_r[DIV_N-1:0];
        div_den   = {16'd0, drive_speed_r};
      end
      S_CT_DIVW: begin
        at_start = div_done;
        at_y     = {2'b00, div_q};
        at_x     = AT_W'(1) <<< COORD_FRAC_BITS;
      end
      S_NUM1: begin
        mul_a = {18'd0, steer_gain_r};
        mul_b = MUL_W'(inner_r);
      end
      S_NUM2: begin
        mul_a = mul_r[MUL_W-1:0];
        mul_b = US_PER_S;
      end
      S_NUM3: begin
        div_start = (dt_r != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  spt_vlen u_vlen (
    .clk   (clk),
    .rst_n (rst_n),
    .start (vlen_start),
    .dx    (vlen_dx),
    .dy    (vlen_dy),
    .done  (vlen_done),
    .len   (vlen_len)
  );

  spt_atan2 u_atan2 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (at_start),
    .y     (at_y),
    .x     (at_x),
    .done  (at_done),
    .angle (at_angle)
  );

  spt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cross_gain_r    <= RST_CROSS_GAIN;
      steer_gain_r    <= RST_STEER_GAIN;
      drive_speed_r   <= RST_DRIVE_SPEED;
      goal_radius_r   <= RST_GOAL_RADIUS;
      point_spacing_r <= RST_POINT_SPACING;
      pose_timeout_r  <= RST_POSE_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CROSS_GAIN:    cross_gain_r    <= cfg_wdata[15:0];
        CFG_STEER_GAIN:    steer_gain_r    <= cfg_wdata[15:0];
        CFG_DRIVE_SPEED:   drive_speed_r   <= cfg_wdata[15:0];
        CFG_GOAL_RADIUS:   goal_radius_r   <= cfg_wdata;
        CFG_POINT_SPACING: point_spacing_r <= cfg_wdata;
        CFG_POSE_TIMEOUT:  pose_timeout_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      path_valid_r <= 1'b0;
      nearest_r    <= '0;
      step_r       <= '0;
      run_r        <= '0;
      anchor_x_r   <= '0;
      anchor_y_r   <= '0;
      prev_time_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cx_r <= in_coord_x;
            cy_r <= in_coord_y;
            case (opcode_t'(in_opcode))
              OP_CLEAR: begin
                count_r      <= '0;
                path_valid_r <= 1'b0;
                nearest_r    <= '0;
                run_r        <= '0;
              end
              OP_APPEND: begin
                if (ram_we) begin
                  if (count_r == '0) begin
                    anchor_x_r <= in_coord_x;
                    anchor_y_r <= in_coord_y;
                  end
                  run_r        <= run_r + CW'(1);
                  count_r      <= count_r + CW'(1);
                  path_valid_r <= 1'b1;
                  nearest_r    <= '0;
                  state_r      <= S_APP_LEN;
                end
              end
              OP_POSE: begin
                prev_time_r <= in_timestamp_us;
                dt_r        <= dt_w;
                hd_r        <= hd_in;
                rd_addr_r   <= last_w[AW-1:0];
                if (path_valid_r && (count_r != '0) && (dt_w <= pose_timeout_r)) begin
                  state_r <= S_GOAL_WAIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_APP_LEN: begin
          if (vlen_done) begin
            if (vlen_len >= point_spacing_r) begin
              step_r     <= step_sum[CW:1];
              run_r      <= '0;
              anchor_x_r <= cx_r;
              anchor_y_r <= cy_r;
            end
            state_r <= S_IDLE;
          end
        end
        S_GOAL_WAIT: state_r <= S_GOAL_GO;
        S_GOAL_GO:   state_r <= S_GOAL_LEN;
        S_GOAL_LEN: begin
          if (vlen_done) begin
            if (vlen_len < goal_radius_r) begin
              res_rate  <= '0;
              res_speed <= '0;
              res_goal  <= 1'b1;
              res_delta <= '0;
              res_dist  <= vlen_len;
              res_idx   <= nearest_r;
              state_r   <= S_OUT;
            end else begin
              idx_r     <= i_start;
              rd_addr_r <= i_start;
              first_r   <= 1'b1;
              state_r   <= S_SR_WAIT;
            end
          end
        end
        S_SR_WAIT: state_r <= S_SR_GO;
        S_SR_GO:   state_r <= S_SR_LEN;
        S_SR_LEN: begin
          if (vlen_done) begin
            first_r <= 1'b0;
            if (!first_r && (dprev_r < vlen_len)) begin
              idx_r   <= AW'(h_r - CW'(1));
              d_r     <= dprev_r;
              state_r <= S_LA;
            end else begin
              if (first_r) begin
                dfirst_r <= vlen_len;
              end
              dprev_r <= vlen_len;
              h_r     <= h_nxt;
              if (h_nxt > last_w) begin
                d_r     <= first_r ? vlen_len : dfirst_r;
                state_r <= S_LA;
              end else begin
                rd_addr_r <= h_nxt[AW-1:0];
                state_r   <= S_SR_WAIT;
              end
            end
          end
        end
        S_LA: begin
          nearest_r <= idx_r;
          rd_addr_r <= idx_r;
          if (la_sum > CW1'(last_w)) begin
            step_r <= last_w - CW'(idx_r);
            j_r    <= last_w[AW-1:0];
          end else begin
            j_r    <= la_sum[AW-1:0];
          end
          state_r <= S_PI_WAIT;
        end
        S_PI_WAIT: state_r <= S_PI_CAP;
        S_PI_CAP: begin
          pix_r     <= ram_x;
          piy_r     <= ram_y;
          rd_addr_r <= j_r;
          state_r   <= S_PJ_WAIT;
        end
        S_PJ_WAIT: state_r <= S_PJ_CAP;
        S_PJ_CAP: begin
          pjx_r   <= ram_x;
          pjy_r   <= ram_y;
          state_r <= S_MUL_A;
        end
        S_MUL_A: state_r <= S_MUL_B;
        S_MUL_B: begin
          p_r     <= mul_r;
          state_r <= S_SIDE;
        end
        S_SIDE: begin
          if (p_r > mul_r) begin
            side_r <= -2'sd1;
          end else if (p_r < mul_r) begin
            side_r <= 2'sd1;
          end else begin
            side_r <= 2'sd0;
          end
          state_r <= S_AT_H;
        end
        S_AT_H: begin
          if (at_done) begin
            delta_r <= 18'(at_angle) - 18'(hd_r);
            if (drive_speed_r == '0) begin
              ct_r    <= HALF_PI_Q13;
              state_r <= S_INNER;
            end else begin
              state_r <= S_CT_MUL;
            end
          end
        end
        S_CT_MUL: state_r <= S_CT_DIV;
        S_CT_DIV: state_r <= S_CT_DIVW;
        S_CT_DIVW: begin
          if (div_done) begin
            state_r <= S_CT_AT;
          end
        end
        S_CT_AT: begin
          if (at_done) begin
            ct_r    <= at_angle;
            state_r <= S_INNER;
          end
        end
        S_INNER: begin
          if (side_r > 0) begin
            inner_r <= delta_r + 18'(ct_r);
          end else if (side_r < 0) begin
            inner_r <= delta_r - 18'(ct_r);
          end else begin
            inner_r <= delta_r;
          end
          state_r <= S_NUM1;
        end
        S_NUM1: state_r <= S_NUM2;
        S_NUM2: state_r <= S_NUM3;
        S_NUM3: begin
          res_speed <= drive_speed_r;
          res_goal  <= 1'b0;
          res_delta <= delta_r[16:0];
          res_dist  <= d_r;
          res_idx   <= idx_r;
          num_neg_r <= mul_r[67];
          if (dt_r == '0) begin
            if (mul_r > 0) begin
              res_rate <= RATE_LIMIT;
            end else if (mul_r < 0) begin
              res_rate <= -RATE_LIMIT;
            end else begin
              res_rate <= '0;
            end
            state_r <= S_OUT;
          end else begin
            state_r <= S_RATE_DIV;
          end
        end
        S_RATE_DIV: begin
          if (div_done) begin
            res_rate <= num_neg_r ? -signed'(rate_mag) : signed'(rate_mag);
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r        <= 1'b1;
            out_angular_rate   <= res_rate;
            out_linear_speed   <= res_speed;
            out_goal_reached   <= res_goal;
            out_heading_error  <= res_delta;
            out_cross_distance <= res_dist;
            out_nearest_index  <= 10'(res_idx);
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(PATH_DEPTH))
    else $error("path length beyond memory depth");

  a_valid_path: assert property (@(posedge clk) disable iff (!rst_n)
    path_valid_r |-> (count_r != '0) && (CW'(nearest_r) < count_r))
    else $error("nearest index outside loaded path");

  a_goal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_goal_reached |-> (out_angular_rate == 0) && (out_linear_speed == 0))
    else $error("goal beat with nonzero speed");

  a_rate_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angular_rate <= RATE_LIMIT) && (out_angular_rate >= -RATE_LIMIT))
    else $error("angular rate beyond limit");

endmodule

// File: hw/rtl/spt_ram.sv
// Generic simple dual-port RAM with registered read.
module spt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/spt_vlen.sv
// Iterative vector length: two squares, then a bit-pair integer square root.
module spt_vlen (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [spt_pkg::DIFF_W-1:0] dx,
  input  logic signed [spt_pkg::DIFF_W-1:0] dy,
  output logic                            done,
  output logic [31:0]                     len
);
  import spt_pkg::*;

  typedef enum logic [2:0] {V_IDLE, V_SQX, V_SQY, V_ADD, V_ROOT} vstate_t;

  vstate_t     state_r;
  logic [32:0] ax, ay;
  logic [30:0] ax_r, ay_r;
  logic [1:0]  s_r;
  logic [63:0] n_r, sq_r, r_r, trial;
  logic [62:0] bit_r;
  logic [33:0] wide;

  assign ax    = dx[DIFF_W-1] ? 33'(-dx) : 33'(dx);
  assign ay    = dy[DIFF_W-1] ? 33'(-dy) : 33'(dy);
  assign trial = r_r + {1'b0, bit_r};
  assign wide  = {2'b00, r_r[31:0]} << s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= V_IDLE;
      done    <= 1'b0;
    end else begin
      done <= (state_r == V_ROOT) && (bit_r == '0);
      case (state_r)
        V_IDLE: begin
          if (start) begin
            if (ax[32] || ay[32]) begin
              ax_r <= ax[32:2];
              ay_r <= ay[32:2];
              s_r  <= 2'd2;
            end else if (ax[31] || ay[31]) begin
              ax_r <= ax[31:1];
              ay_r <= ay[31:1];
              s_r  <= 2'd1;
            end else begin
              ax_r <= ax[30:0];
              ay_r <= ay[30:0];
              s_r  <= 2'd0;
            end
            state_r <= V_SQX;
          end
        end
        V_SQX: begin
          n_r     <= 64'(ax_r) * 64'(ax_r);
          state_r <= V_SQY;
        end
        V_SQY: begin
          sq_r    <= 64'(ay_r) * 64'(ay_r);
          state_r <= V_ADD;
        end
        V_ADD: begin
          n_r     <= n_r + sq_r;
          r_r     <= '0;
          bit_r   <= 63'd1 << 62;
          state_r <= V_ROOT;
        end
        V_ROOT: begin
          if (bit_r == '0) begin
            len     <= (wide[33:32] != 2'b00) ? 32'hFFFF_FFFF : wide[31:0];
            state_r <= V_IDLE;
          end else begin
            if (n_r >= trial) begin
              n_r <= n_r - trial;
              r_r <= (r_r >> 1) + {1'b0, bit_r};
            end else begin
              r_r <= r_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end
        end
        default: state_r <= V_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/spt_atan2.sv
// Iterative atan2: one normalizing shift per cycle, then 24 CORDIC steps.
module spt_atan2 (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [spt_pkg::AT_W-1:0] y,
  input  logic signed [spt_pkg::AT_W-1:0] x,
  output logic                           done,
  output logic signed [15:0]             angle
);
  import spt_pkg::*;

  typedef enum logic [1:0] {A_IDLE, A_NORM, A_ROT, A_FIN} astate_t;

  astate_t            state_r;
  logic [AT_W-1:0]    ax_r, ay_r;
  logic               xneg_r, yneg_r, zero_r;
  logic signed [33:0] cx_r, cy_r, shx, shy;
  logic signed [31:0] z_r, zc, zf;
  logic [4:0]         k_r;
  logic [31:0]        zr;
  logic signed [15:0] t;

  function automatic logic signed [33:0] tdiv(input logic signed [33:0] v,
                                              input logic [4:0] k);
    logic signed [33:0] m;
    m = -v;
    return v[33] ? -(m >>> k) : (v >>> k);
  endfunction

  assign shx = tdiv(cx_r, k_r);
  assign shy = tdiv(cy_r, k_r);

  always_comb begin
    zc = z_r;
    if (z_r < 0) begin
      zc = '0;
    end else if (z_r > HALF_PI_Q28) begin
      zc = HALF_PI_Q28;
    end
    zf = xneg_r ? (PI_Q28 - zc) : zc;
    zr = 32'(zf) + 32'd16384;
    t  = signed'(16'(zr >> 15));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done    <= 1'b0;
    end else begin
      done <= (state_r == A_FIN);
      case (state_r)
        A_IDLE: begin
          if (start) begin
            xneg_r  <= x[AT_W-1];
            yneg_r  <= y[AT_W-1];
            zero_r  <= (x == '0) && (y == '0);
            ax_r    <= x[AT_W-1] ? AT_W'(-x) : AT_W'(x);
            ay_r    <= y[AT_W-1] ? AT_W'(-y) : AT_W'(y);
            state_r <= ((x == '0) && (y == '0)) ? A_FIN : A_NORM;
          end
        end
        A_NORM: begin
          if ((ax_r[AT_W-1:30] != '0) || (ay_r[AT_W-1:30] != '0)) begin
            ax_r <= ax_r >> 1;
            ay_r <= ay_r >> 1;
          end else if ((ax_r[AT_W-1:29] == '0) && (ay_r[AT_W-1:29] == '0)) begin
            ax_r <= ax_r << 1;
            ay_r <= ay_r << 1;
          end else begin
            cx_r    <= 34'(ax_r[29:0]);
            cy_r    <= 34'(ay_r[29:0]);
            z_r     <= '0;
            k_r     <= '0;
            state_r <= A_ROT;
          end
        end
        A_ROT: begin
          if (cy_r >= 0) begin
            cx_r <= cx_r + shy;
            cy_r <= cy_r - shx;
            z_r  <= z_r + atan_step(k_r);
          end else begin
            cx_r <= cx_r - shy;
            cy_r <= cy_r + shx;
            z_r  <= z_r - atan_step(k_r);
          end
          k_r <= k_r + 5'd1;
          if (k_r == 5'(CORDIC_STEPS - 1)) begin
            state_r <= A_FIN;
          end
        end
        A_FIN: begin
          angle   <= zero_r ? 16'sd0 : (yneg_r ? -t : t);
          state_r <= A_IDLE;
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/spt_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module spt_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [spt_pkg::DIV_N-1:0]  dividend,
  input  logic [spt_pkg::DIV_D-1:0]  divisor,
  output logic                       done,
  output logic [spt_pkg::DIV_N-1:0]  quotient
);
  import spt_pkg::*;

  localparam int CNT_W = $clog2(DIV_N);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_D-1:0] div_r, rem_r;
  logic [DIV_D:0]   rem_sh, rem_sub;

  assign rem_sh  = {rem_r, quotient[DIV_N-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= busy_r && (cnt_r == CNT_W'(DIV_N - 1));
      if (!busy_r) begin
        if (start) begin
          quotient <= dividend;
          div_r    <= divisor;
          rem_r    <= '0;
          cnt_r    <= '0;
          busy_r   <= 1'b1;
        end
      end else begin
        if (rem_sh >= {1'b0, div_r}) begin
          rem_r    <= rem_sub[DIV_D-1:0];
          quotient <= {quotient[DIV_N-2:0], 1'b1};
        end else begin
          rem_r    <= rem_sh[DIV_D-1:0];
          quotient <= {quotient[DIV_N-2:0], 1'b0};
        end
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_N - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule
